// ===== rtl/dsc_pkg.sv =====
// Package for the depth to spectrum color block: widths, segment and factor codes,
// reciprocal constants for the exact constant divisions, and the gamma table.
// Used by the channel interfaces and by the top level.
package dsc_pkg;

    localparam int DEPTH_BITS       = 16;
    localparam int GAMMA_TABLE_BITS = 10;
    localparam int GT_SIZE          = 1 << GAMMA_TABLE_BITS;
    localparam int COLOR_BITS       = 8;
    localparam int Q12_BITS         = 13;
    localparam int OFS_BITS         = 10;
    localparam int PIPE_STAGES      = 6;

    localparam logic [Q12_BITS-1:0] ONE_Q12 = 13'd4096;

    // Spectrum limits as offsets from 380 nm in tenths of a nanometer.
    localparam int DEPTH_MAX  = 4000;
    localparam int EDGE_BLUE  = 600;
    localparam int EDGE_CYAN  = 1100;
    localparam int EDGE_GREEN = 1300;
    localparam int EDGE_ORNG  = 2000;
    localparam int EDGE_RED   = 2650;
    localparam int FAC_LOW    = 400;
    localparam int FAC_HIGH   = 3200;

    // Division of t * 4096 by a constant D as (t * M) >> RECIP_SHIFT, exact while
    // t * D stays below 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_BITS  = 32;
    localparam logic [63:0] RECIP_NUM = 64'd1 << (RECIP_SHIFT + 12);
    localparam logic [RECIP_BITS-1:0] RECIP_600  = 32'((RECIP_NUM + 64'd599) / 64'd600);
    localparam logic [RECIP_BITS-1:0] RECIP_500  = 32'((RECIP_NUM + 64'd499) / 64'd500);
    localparam logic [RECIP_BITS-1:0] RECIP_200  = 32'((RECIP_NUM + 64'd199) / 64'd200);
    localparam logic [RECIP_BITS-1:0] RECIP_700  = 32'((RECIP_NUM + 64'd699) / 64'd700);
    localparam logic [RECIP_BITS-1:0] RECIP_650  = 32'((RECIP_NUM + 64'd649) / 64'd650);
    localparam logic [RECIP_BITS-1:0] RECIP_4000 = 32'((RECIP_NUM + 64'd3999) / 64'd4000);
    localparam logic [RECIP_BITS-1:0] RECIP_8000 = 32'((RECIP_NUM + 64'd7999) / 64'd8000);

    typedef enum logic [2:0] {
        SEG_VIOLET,
        SEG_BLUE,
        SEG_CYAN,
        SEG_GREEN,
        SEG_ORANGE,
        SEG_RED,
        SEG_NONE
    } t_seg;

    typedef enum logic [1:0] {
        FAC_RISE,
        FAC_FLAT,
        FAC_FALL,
        FAC_ZERO
    } t_fac;

    typedef struct packed {
        logic [Q12_BITS-1:0] red;
        logic [Q12_BITS-1:0] green;
        logic [Q12_BITS-1:0] blue;
    } t_rgb_q12;

    typedef struct packed {
        logic [GAMMA_TABLE_BITS-1:0] red;
        logic [GAMMA_TABLE_BITS-1:0] green;
        logic [GAMMA_TABLE_BITS-1:0] blue;
    } t_rgb_idx;

    typedef logic [COLOR_BITS-1:0] t_gamma_rom [GT_SIZE];

    // Entry i is the largest y with y^5 * n^4 <= 255^5 * i^4, n = GT_SIZE - 1.
    function automatic t_gamma_rom build_gamma_rom();
        t_gamma_rom  rom;
        logic [127:0] nw;
        logic [127:0] n4;
        logic [127:0] k5;
        logic [127:0] iw;
        logic [127:0] i4;
        logic [127:0] yw;
        int          y;
        nw = 128'(GT_SIZE - 1);
        n4 = nw * nw * nw * nw;
        k5 = 128'd255 * 128'd255 * 128'd255 * 128'd255 * 128'd255;
        y  = 0;
        for (int i = 0; i < GT_SIZE; i++) begin
            iw = 128'(i);
            i4 = iw * iw * iw * iw;
            yw = 128'(y + 1);
            while (y < 255 && (yw * yw * yw * yw * yw * n4) <= (k5 * i4)) begin
                y  = y + 1;
                yw = 128'(y + 1);
            end
            rom[i] = COLOR_BITS'(y);
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = build_gamma_rom();

endpackage

// ===== rtl/dsc_depth_if.sv =====
// Channel interface for depth items: valid, ready and one depth sample.
// Depends on dsc_pkg for the sample width.
interface dsc_depth_if;
    import dsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [DEPTH_BITS-1:0] depth_sample;

    modport source (output valid, output depth_sample, input ready);
    modport sink (input valid, input depth_sample, output ready);
endinterface

// ===== rtl/dsc_color_if.sv =====
// Channel interface for color items: valid, ready and the red, green and blue values.
// Depends on dsc_pkg for the component width.
interface dsc_color_if;
    import dsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// ===== rtl/depth_to_spectrum_color.sv =====
// Depth to spectrum color: maps each depth item to an RGB item on the visible spectrum.
// A result is registered in every stage, from the decode to the gamma table read, before it is valid at the output.
// One item per cycle is taken; a stage holds only while the stage after it is full and
// stalled, so bubbles close up and only a stalled output slows the input.
// Synchronous active-low reset clears all stage valid bits; payload is not reset.
// Depends on dsc_pkg, dsc_depth_if and dsc_color_if.
module depth_to_spectrum_color (
    input logic          i_clk,
    input logic          i_rst_n,
    dsc_depth_if.sink    i_depth,
    dsc_color_if.source  o_color
);
    import dsc_pkg::*;

    localparam int CPROD_BITS = OFS_BITS + RECIP_BITS;
    localparam int FPROD_BITS = Q12_BITS + RECIP_BITS;
    localparam int PPROD_BITS = 2 * Q12_BITS;
    localparam int IPROD_BITS = Q12_BITS + GAMMA_TABLE_BITS;

    logic [PIPE_STAGES-1:0] r_valid;
    logic [PIPE_STAGES-1:0] adv;

    always_comb begin
        adv[PIPE_STAGES-1] = !r_valid[PIPE_STAGES-1] || o_color.ready;
        for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_valid[k] || adv[k+1];
        end
    end

    assign i_depth.ready = adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= i_depth.valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++) begin
                if (adv[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // Stage 1: segment and factor decode, offsets for the constant divisions.
    t_seg                r_s1_seg, n_s1_seg;
    t_fac                r_s1_fac, n_s1_fac;
    logic [OFS_BITS-1:0] r_s1_tc, n_s1_tc;
    logic [Q12_BITS-1:0] r_s1_fn, n_s1_fn;

    always_comb begin
        logic [DEPTH_BITS-1:0] d;
        d        = i_depth.depth_sample;
        n_s1_tc  = '0;
        n_s1_fn  = '0;
        if (d > DEPTH_MAX) begin
            n_s1_seg = SEG_NONE;
        end else if (d < EDGE_BLUE) begin
            n_s1_seg = SEG_VIOLET;
            n_s1_tc  = OFS_BITS'(EDGE_BLUE - int'(d));
        end else if (d < EDGE_CYAN) begin
            n_s1_seg = SEG_BLUE;
            n_s1_tc  = OFS_BITS'(int'(d) - EDGE_BLUE);
        end else if (d < EDGE_GREEN) begin
            n_s1_seg = SEG_CYAN;
            n_s1_tc  = OFS_BITS'(EDGE_GREEN - int'(d));
        end else if (d < EDGE_ORNG) begin
            n_s1_seg = SEG_GREEN;
            n_s1_tc  = OFS_BITS'(int'(d) - EDGE_GREEN);
        end else if (d < EDGE_RED) begin
            n_s1_seg = SEG_ORANGE;
            n_s1_tc  = OFS_BITS'(EDGE_RED - int'(d));
        end else begin
            n_s1_seg = SEG_RED;
        end
        if (d > DEPTH_MAX) begin
            n_s1_fac = FAC_ZERO;
        end else if (d < FAC_LOW) begin
            n_s1_fac = FAC_RISE;
            n_s1_fn  = Q12_BITS'(1200 + 7 * int'(d));
        end else if (d < FAC_HIGH) begin
            n_s1_fac = FAC_FLAT;
        end else begin
            n_s1_fac = FAC_FALL;
            n_s1_fn  = Q12_BITS'(2400 + 7 * (DEPTH_MAX - int'(d)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_s1_seg <= n_s1_seg;
            r_s1_fac <= n_s1_fac;
            r_s1_tc  <= n_s1_tc;
            r_s1_fn  <= n_s1_fn;
        end
    end

    // Stage 2: reciprocal multiplications.
    t_seg                  r_s2_seg;
    t_fac                  r_s2_fac;
    logic [CPROD_BITS-1:0] r_s2_cprod, n_s2_cprod;
    logic [FPROD_BITS-1:0] r_s2_fprod, n_s2_fprod;

    always_comb begin
        logic [RECIP_BITS-1:0] mc;
        logic [RECIP_BITS-1:0] mf;
        case (r_s1_seg)
            SEG_VIOLET: mc = RECIP_600;
            SEG_BLUE:   mc = RECIP_500;
            SEG_CYAN:   mc = RECIP_200;
            SEG_GREEN:  mc = RECIP_700;
            SEG_ORANGE: mc = RECIP_650;
            default:    mc = '0;
        endcase
        case (r_s1_fac)
            FAC_RISE: mf = RECIP_4000;
            FAC_FALL: mf = RECIP_8000;
            default:  mf = '0;
        endcase
        n_s2_cprod = CPROD_BITS'(r_s1_tc) * CPROD_BITS'(mc);
        n_s2_fprod = FPROD_BITS'(r_s1_fn) * FPROD_BITS'(mf);
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s2_seg   <= r_s1_seg;
            r_s2_fac   <= r_s1_fac;
            r_s2_cprod <= n_s2_cprod;
            r_s2_fprod <= n_s2_fprod;
        end
    end

    // Stage 3: components and intensity factor in Q1.12.
    t_rgb_q12            r_s3_comp, n_s3_comp;
    logic [Q12_BITS-1:0] r_s3_fq, n_s3_fq;

    always_comb begin
        logic [Q12_BITS-1:0] cq;
        cq        = r_s2_cprod[RECIP_SHIFT+Q12_BITS-1:RECIP_SHIFT];
        n_s3_comp = '0;
        case (r_s2_seg)
            SEG_VIOLET: begin
                n_s3_comp.red  = cq;
                n_s3_comp.blue = ONE_Q12;
            end
            SEG_BLUE: begin
                n_s3_comp.green = cq;
                n_s3_comp.blue  = ONE_Q12;
            end
            SEG_CYAN: begin
                n_s3_comp.green = ONE_Q12;
                n_s3_comp.blue  = cq;
            end
            SEG_GREEN: begin
                n_s3_comp.red   = cq;
                n_s3_comp.green = ONE_Q12;
            end
            SEG_ORANGE: begin
                n_s3_comp.red   = ONE_Q12;
                n_s3_comp.green = cq;
            end
            SEG_RED: begin
                n_s3_comp.red = ONE_Q12;
            end
            default: begin
                n_s3_comp = '0;
            end
        endcase
        case (r_s2_fac)
            FAC_RISE: n_s3_fq = r_s2_fprod[RECIP_SHIFT+Q12_BITS-1:RECIP_SHIFT];
            FAC_FALL: n_s3_fq = r_s2_fprod[RECIP_SHIFT+Q12_BITS-1:RECIP_SHIFT];
            FAC_FLAT: n_s3_fq = ONE_Q12;
            default:  n_s3_fq = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r_s3_comp <= n_s3_comp;
            r_s3_fq   <= n_s3_fq;
        end
    end

    // Stage 4: scale each component by the factor.
    t_rgb_q12 r_s4_p, n_s4_p;

    always_comb begin
        logic [PPROD_BITS-1:0] pr;
        logic [PPROD_BITS-1:0] pg;
        logic [PPROD_BITS-1:0] pb;
        pr           = PPROD_BITS'(r_s3_comp.red) * PPROD_BITS'(r_s3_fq);
        pg           = PPROD_BITS'(r_s3_comp.green) * PPROD_BITS'(r_s3_fq);
        pb           = PPROD_BITS'(r_s3_comp.blue) * PPROD_BITS'(r_s3_fq);
        n_s4_p.red   = pr[Q12_BITS+11:12];
        n_s4_p.green = pg[Q12_BITS+11:12];
        n_s4_p.blue  = pb[Q12_BITS+11:12];
    end

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r_s4_p <= n_s4_p;
        end
    end

    // Stage 5: gamma table index, p * (GT_SIZE - 1) / 4096.
    t_rgb_idx r_s5_idx, n_s5_idx;

    always_comb begin
        logic [IPROD_BITS-1:0] ir;
        logic [IPROD_BITS-1:0] ig;
        logic [IPROD_BITS-1:0] ib;
        ir = (IPROD_BITS'(r_s4_p.red) << GAMMA_TABLE_BITS) - IPROD_BITS'(r_s4_p.red);
        ig = (IPROD_BITS'(r_s4_p.green) << GAMMA_TABLE_BITS) - IPROD_BITS'(r_s4_p.green);
        ib = (IPROD_BITS'(r_s4_p.blue) << GAMMA_TABLE_BITS) - IPROD_BITS'(r_s4_p.blue);
        n_s5_idx.red   = ir[GAMMA_TABLE_BITS+11:12];
        n_s5_idx.green = ig[GAMMA_TABLE_BITS+11:12];
        n_s5_idx.blue  = ib[GAMMA_TABLE_BITS+11:12];
    end

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r_s5_idx <= n_s5_idx;
        end
    end

    // Stage 6: registered gamma table read.
    logic [COLOR_BITS-1:0] r_s6_red;
    logic [COLOR_BITS-1:0] r_s6_green;
    logic [COLOR_BITS-1:0] r_s6_blue;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r_s6_red   <= GAMMA_ROM[r_s5_idx.red];
            r_s6_green <= GAMMA_ROM[r_s5_idx.green];
            r_s6_blue  <= GAMMA_ROM[r_s5_idx.blue];
        end
    end

    assign o_color.valid = r_valid[PIPE_STAGES-1];
    assign o_color.red   = r_s6_red;
    assign o_color.green = r_s6_green;
    assign o_color.blue  = r_s6_blue;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for depth_to_spectrum_color: drives depth items, predicts each RGB item and
// compares it with the item that comes out, under random idling on both channels.
// Depends on dsc_pkg, dsc_depth_if, dsc_color_if and the depth_to_spectrum_color RTL.
`timescale 1ns / 1ps

module tb_top;
    import dsc_pkg::*;

    localparam int W_BASE      = 3800;
    localparam int Q_ONE       = 4096;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 96;
    localparam int NUM_CASES   = 25;
    localparam int NUM_EDGES   = 8;

    typedef struct packed {
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_color;

    typedef struct packed {
        logic [DEPTH_BITS-1:0] depth;
        logic                  typed;
        t_color                color;
    } t_depth_case;

    localparam t_color BLACK = '0;

    // Rows marked typed carry a color read straight off the spectrum rule.
    localparam t_depth_case DIRECTED [NUM_CASES] = '{
        '{16'd0,     1'b0, BLACK}, '{16'd1,     1'b0, BLACK}, '{16'd399,   1'b0, BLACK},
        '{16'd400,   1'b0, BLACK}, '{16'd599,   1'b0, BLACK}, '{16'd600,   1'b0, BLACK},
        '{16'd601,   1'b0, BLACK}, '{16'd1099,  1'b0, BLACK}, '{16'd1100,  1'b0, BLACK},
        '{16'd1299,  1'b0, BLACK}, '{16'd1300,  1'b0, BLACK}, '{16'd1999,  1'b0, BLACK},
        '{16'd2000,  1'b0, BLACK}, '{16'd2649,  1'b0, BLACK}, '{16'd2650,  1'b0, BLACK},
        '{16'd3199,  1'b0, BLACK}, '{16'd3200,  1'b0, BLACK}, '{16'd3999,  1'b0, BLACK},
        '{16'd4000,  1'b0, BLACK}, '{16'd4001,  1'b1, BLACK}, '{16'd5000,  1'b1, BLACK},
        '{16'd32768, 1'b1, BLACK}, '{16'd43690, 1'b1, BLACK}, '{16'd21845, 1'b1, BLACK},
        '{16'd65535, 1'b1, BLACK}
    };

    localparam int SEG_EDGES [NUM_EDGES] = '{400, 600, 1100, 1300, 2000, 2650, 3200, 4000};

    logic clk;
    logic rst_n;

    dsc_depth_if depth_ch ();
    dsc_color_if color_ch ();

    depth_to_spectrum_color u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_depth (depth_ch),
        .o_color (color_ch)
    );

    logic [COLOR_BITS-1:0] gamma_curve [GT_SIZE];
    t_color                expected_colors [$];
    int                    error_count;
    int                    sender_idle_pct;
    int                    stall_pct;
    bit                    long_hold_req;
    int                    cycle_count;

    function automatic logic [COLOR_BITS-1:0] gamma_scale(longint unsigned comp,
                                                          longint unsigned fac);
        longint unsigned prod;
        longint unsigned idx;
        if (comp == 0) begin
            return '0;
        end
        prod = (comp * fac) >> 12;
        idx  = (prod * (GT_SIZE - 1)) >> 12;
        if (idx > GT_SIZE - 1) begin
            idx = GT_SIZE - 1;
        end
        return gamma_curve[idx];
    endfunction

    function automatic t_color spectrum_rgb(logic [DEPTH_BITS-1:0] depth);
        longint unsigned w;
        longint unsigned r;
        longint unsigned g;
        longint unsigned b;
        longint unsigned f;
        t_seg            seg;
        t_fac            fac_kind;
        t_color          color;
        w = longint'(depth) + W_BASE;
        r = 0;
        g = 0;
        b = 0;
        f = 0;
        if (w < 4400) seg = SEG_VIOLET;
        else if (w < 4900) seg = SEG_BLUE;
        else if (w < 5100) seg = SEG_CYAN;
        else if (w < 5800) seg = SEG_GREEN;
        else if (w < 6450) seg = SEG_ORANGE;
        else if (w <= 7800) seg = SEG_RED;
        else seg = SEG_NONE;
        case (seg)
            SEG_VIOLET: begin
                r = (4400 - w) * Q_ONE / 600;
                b = Q_ONE;
            end
            SEG_BLUE: begin
                g = (w - 4400) * Q_ONE / 500;
                b = Q_ONE;
            end
            SEG_CYAN: begin
                g = Q_ONE;
                b = (5100 - w) * Q_ONE / 200;
            end
            SEG_GREEN: begin
                r = (w - 5100) * Q_ONE / 700;
                g = Q_ONE;
            end
            SEG_ORANGE: begin
                r = Q_ONE;
                g = (6450 - w) * Q_ONE / 650;
            end
            SEG_RED: begin
                r = Q_ONE;
            end
            default: begin
            end
        endcase
        if (w < 4200) fac_kind = FAC_RISE;
        else if (w < 7000) fac_kind = FAC_FLAT;
        else if (w <= 7800) fac_kind = FAC_FALL;
        else fac_kind = FAC_ZERO;
        case (fac_kind)
            FAC_RISE: f = Q_ONE * (1200 + 7 * (w - 3800)) / 4000;
            FAC_FLAT: f = Q_ONE;
            FAC_FALL: f = Q_ONE * (2400 + 7 * (7800 - w)) / 8000;
            default:  f = 0;
        endcase
        color.red   = gamma_scale(r, f);
        color.green = gamma_scale(g, f);
        color.blue  = gamma_scale(b, f);
        return color;
    endfunction

    task automatic send_depth(input logic [DEPTH_BITS-1:0] depth, input logic typed,
                              input t_color typed_color);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            depth_ch.valid        <= 1'b0;
            depth_ch.depth_sample <= DEPTH_BITS'($urandom);
            @(posedge clk);
        end
        depth_ch.valid        <= 1'b1;
        depth_ch.depth_sample <= depth;
        @(posedge clk);
        while (!depth_ch.ready) begin
            @(posedge clk);
        end
        expected_colors.push_back(typed ? typed_color : spectrum_rgb(depth));
    endtask

    function automatic logic [DEPTH_BITS-1:0] random_depth();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 80) begin
            return DEPTH_BITS'($urandom_range(0, 4000));
        end else if (sel < 92) begin
            return DEPTH_BITS'(SEG_EDGES[$urandom_range(0, NUM_EDGES - 1)]
                               + $urandom_range(0, 6) - 3);
        end
        return DEPTH_BITS'($urandom_range(0, 65535));
    endfunction

    task automatic compare_field(input string name, input logic [COLOR_BITS-1:0] exp_val,
                                 input logic [COLOR_BITS-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            error_count++;
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("depth_to_spectrum_color verification failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request while items keep coming.
    initial begin
        color_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                color_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            color_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        t_color exp_color;
        if (rst_n && color_ch.valid && color_ch.ready) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected color item: red %0d green %0d blue %0d",
                       color_ch.red, color_ch.green, color_ch.blue);
                error_count++;
            end else begin
                exp_color = expected_colors.pop_front();
                compare_field("red", exp_color.red, color_ch.red);
                compare_field("green", exp_color.green, color_ch.green);
                compare_field("blue", exp_color.blue, color_ch.blue);
            end
        end
    end

    initial begin
        logic [127:0] n4;
        logic [127:0] k5;
        logic [127:0] i4;
        logic [127:0] yw;
        int           lo;
        int           hi;
        int           mid;
        int           idle_plan  [5];
        int           stall_plan [5];

        error_count     = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        long_hold_req   = 1'b0;
        rst_n                 <= 1'b0;
        depth_ch.valid        <= 1'b0;
        depth_ch.depth_sample <= '0;

        // Gamma curve: largest y with y^5 * n^4 <= 255^5 * i^4, found by bisection.
        n4 = 128'(GT_SIZE - 1) * 128'(GT_SIZE - 1) * 128'(GT_SIZE - 1) * 128'(GT_SIZE - 1);
        k5 = 128'd255 * 128'd255 * 128'd255 * 128'd255 * 128'd255;
        for (int i = 0; i < GT_SIZE; i++) begin
            i4 = 128'(i) * 128'(i) * 128'(i) * 128'(i);
            lo = 0;
            hi = 255;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                yw  = 128'(mid);
                if (yw * yw * yw * yw * yw * n4 <= k5 * i4) lo = mid;
                else hi = mid - 1;
            end
            gamma_curve[i] = COLOR_BITS'(lo);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int n = 0; n < NUM_CASES; n++) begin
            send_depth(DIRECTED[n].depth, DIRECTED[n].typed, DIRECTED[n].color);
        end

        idle_plan  = '{0, 83, 0, 34, 0};
        stall_plan = '{0, 0, 83, 34, 0};
        for (int ph = 0; ph < 5; ph++) begin
            sender_idle_pct = idle_plan[ph];
            stall_pct       = stall_plan[ph];
            if (ph == 4) begin
                long_hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_depth(random_depth(), 1'b0, BLACK);
            end
        end
        depth_ch.valid <= 1'b0;

        while (expected_colors.size() != 0) begin
            @(posedge clk);
        end
        repeat (4 * PIPE_STAGES) @(posedge clk);

        if (error_count == 0) begin
            $display("depth_to_spectrum_color verification clean");
        end else begin
            $display("depth_to_spectrum_color verification failed");
        end
        $finish;
    end

endmodule
